FILE: rtl/telegram_frame_segmenter_macros.svh
// ----------------------------------------------------------------------------
// Telegram frame segmenter assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TELEGRAM_FRAME_SEGMENTER_MACROS_SVH
`define TELEGRAM_FRAME_SEGMENTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TFS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("telegram segmenter check failed");

// Next-cycle implication, checked outside reset
`define TFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("telegram segmenter check failed");

`endif

FILE: rtl/tfs_pkg.sv
// ----------------------------------------------------------------------------
// Telegram frame segmenter package
// Item and result types, frame marks and header packing shared by the block.
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int unsigned FRAME_BYTES = 8;

	localparam logic [7:0]  START_MARK       = 8'h80;
	localparam logic [7:0]  CONT_MARK        = 8'hC0;
	localparam logic [15:0] MAX_BODY_LEN     = 16'd255;
	localparam logic [7:0]  SHORT_MAX_LEN    = 8'd6;
	localparam logic [7:0]  START_BODY_BYTES = 8'd4;
	localparam logic [3:0]  FILL_SHORT_HDR   = 4'd2;
	localparam logic [3:0]  FILL_START_HDR   = 4'd4;
	localparam logic [3:0]  FILL_CONT_HDR    = 4'd1;
	localparam logic [3:0]  FILL_FULL        = 4'd8;

	typedef logic [7:0] byte_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_REFUSED = 1'b1
	} status_t;

	typedef struct packed {
		logic [3:0]  op_code;
		logic [5:0]  unit_id;
		logic [5:0]  function_id;
		logic [1:0]  group_id;
		logic [15:0] body_len;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		byte_t [FRAME_BYTES-1:0] frame;
		logic [3:0]              frame_len;
		status_t                 status;
		logic                    last_frame;
		logic [5:0]              frame_count;
	} result_t;

	// Pack opcode, unit and function into the two header bytes
	function automatic logic [15:0] pack_header(input item_t it);
		byte_t h0;
		byte_t h1;
		h0 = {it.op_code, it.unit_id[5:2]};
		h1 = {it.unit_id[1:0], it.function_id};
		return {h1, h0};
	endfunction

endpackage

FILE: rtl/tfs_in_reg.sv
// ----------------------------------------------------------------------------
// Telegram frame segmenter input register
// Captures one input transaction per cycle, unless the segmenting logic stalls, ahead of the segmenting logic.
// ----------------------------------------------------------------------------
module tfs_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tfs_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output tfs_pkg::item_t item_s1
);
	import tfs_pkg::*;

	// Take a new transaction whenever the stage is empty or moving on
	assign in_ready = !valid_s1 || advance;

	// Hold the stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load payload on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/tfs_seg_core.sv
// ----------------------------------------------------------------------------
// Telegram frame segmenter core
// Holds the telegram state and builds short, start and continuation frames.
// ----------------------------------------------------------------------------
module tfs_seg_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  tfs_pkg::item_t   item_s1,
	input  logic             out_free,
	output logic             advance,
	output logic             res_valid,
	output tfs_pkg::result_t res
);
	import tfs_pkg::*;

	logic [7:0]                bytes_q;
	byte_t [FRAME_BYTES-1:0]   store_q;
	logic [3:0]                fill_q;
	logic [3:0]                cont_q;
	logic [5:0]                frames_q;
	logic [7:0]                held_len_q;
	logic [1:0]                held_grp_q;

	logic                      first;
	logic                      too_long;
	logic                      empty_body;
	logic [7:0]                eff_len;
	logic [1:0]                eff_grp;
	logic                      long_body;
	logic [15:0]               hdr;
	byte_t [FRAME_BYTES-1:0]   store_n;
	logic [3:0]                fill_w;
	logic [3:0]                fill_inc;
	logic [7:0]                bytes_inc;
	logic                      done;
	logic [5:0]                frames_base;
	logic [5:0]                frames_inc;
	logic [3:0]                cont_base;

	logic [7:0]                bytes_n;
	logic [3:0]                fill_n;
	logic [3:0]                cont_n;
	logic [5:0]                frames_n;
	logic [3:0]                emit_len;
	logic                      emit_last;
	logic [5:0]                emit_count;
	status_t                   emit_status;

	// Decode the item against the telegram state
	always_comb begin
		first      = (bytes_q == 8'd0);
		too_long   = item_s1.body_len > MAX_BODY_LEN;
		empty_body = (item_s1.body_len == 16'd0);
		eff_len    = first ? item_s1.body_len[7:0] : held_len_q;
		eff_grp    = first ? item_s1.group_id : held_grp_q;
		long_body  = eff_len > SHORT_MAX_LEN;
		hdr        = pack_header(item_s1);
		frames_base = first ? 6'd0 : frames_q;
		cont_base   = first ? 4'd0 : cont_q;
		frames_inc  = frames_base + 6'd1;
	end

	// Place header bytes, then the data byte at the fill position
	always_comb begin
		store_n = store_q;
		fill_w  = fill_q;
		if (first) begin
			if (long_body) begin
				store_n[0] = START_MARK | {2'b00, eff_grp, 4'b0000};
				store_n[1] = eff_len;
				store_n[2] = hdr[7:0];
				store_n[3] = hdr[15:8];
				fill_w     = FILL_START_HDR;
			end else begin
				store_n[0] = hdr[7:0];
				store_n[1] = hdr[15:8];
				fill_w     = FILL_SHORT_HDR;
			end
		end else if (long_body && bytes_q >= START_BODY_BYTES && fill_q == 4'd0) begin
			store_n[0] = CONT_MARK | {2'b00, eff_grp, cont_q};
			fill_w     = FILL_CONT_HDR;
		end
		store_n[fill_w[2:0]] = item_s1.data_byte;
		fill_inc  = fill_w + 4'd1;
		bytes_inc = bytes_q + 8'd1;
		done      = (bytes_inc == eff_len);
	end

	// Choose the result and the next state
	always_comb begin
		res_valid   = 1'b0;
		emit_len    = fill_inc;
		emit_last   = 1'b0;
		emit_count  = frames_inc;
		emit_status = ST_OK;
		bytes_n     = bytes_inc;
		fill_n      = fill_inc;
		cont_n      = cont_base;
		frames_n    = frames_base;
		if (first && too_long) begin
			// Refuse: no frame, keep idle
			res_valid   = 1'b1;
			emit_len    = 4'd0;
			emit_last   = 1'b1;
			emit_count  = 6'd0;
			emit_status = ST_REFUSED;
			bytes_n     = 8'd0;
			fill_n      = 4'd0;
			cont_n      = cont_q;
			frames_n    = frames_q;
		end else if (first && empty_body) begin
			// Header-only short frame
			res_valid  = 1'b1;
			emit_len   = FILL_SHORT_HDR;
			emit_last  = 1'b1;
			emit_count = 6'd1;
			bytes_n    = 8'd0;
			fill_n     = 4'd0;
			frames_n   = 6'd1;
		end else if (!long_body) begin
			if (done) begin
				res_valid  = 1'b1;
				emit_last  = 1'b1;
				emit_count = 6'd1;
				bytes_n    = 8'd0;
				fill_n     = 4'd0;
				frames_n   = 6'd1;
			end
		end else if (bytes_inc == START_BODY_BYTES) begin
			// Start frame complete
			res_valid = 1'b1;
			emit_len  = FILL_FULL;
			fill_n    = 4'd0;
			frames_n  = frames_inc;
		end else if (fill_inc >= FILL_FULL || done) begin
			// Continuation frame complete
			res_valid = 1'b1;
			emit_last = done;
			fill_n    = 4'd0;
			frames_n  = frames_inc;
			cont_n    = cont_base + 4'd1;
			if (done) begin
				bytes_n = 8'd0;
			end
		end
	end

	// Mask bytes beyond the frame length
	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			res.frame[i] = (4'(i) < emit_len) ? store_n[i] : 8'd0;
		end
		res.frame_len   = emit_len;
		res.status      = emit_status;
		res.last_frame  = emit_last;
		res.frame_count = emit_count;
	end

	// Move on unless a result has nowhere to go
	assign advance = valid_s1 && (!res_valid || out_free);

	// Update telegram control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q    <= 8'd0;
			fill_q     <= 4'd0;
			cont_q     <= 4'd0;
			frames_q   <= 6'd0;
			held_len_q <= 8'd0;
			held_grp_q <= 2'd0;
		end else if (advance) begin
			bytes_q  <= bytes_n;
			fill_q   <= fill_n;
			cont_q   <= cont_n;
			frames_q <= frames_n;
			if (first && !too_long) begin
				held_len_q <= item_s1.body_len[7:0];
				held_grp_q <= item_s1.group_id;
			end
		end
	end

	// Frame bytes under construction
	always_ff @(posedge clk) begin
		if (advance) begin
			store_q <= store_n;
		end
	end

endmodule

FILE: rtl/tfs_out_reg.sv
// ----------------------------------------------------------------------------
// Telegram frame segmenter output register
// Holds one finished frame until the sink takes the transaction.
// ----------------------------------------------------------------------------
module tfs_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tfs_pkg::result_t res,
	input  logic             out_ready,
	output logic             out_free,
	output logic             res_valid_s2,
	output tfs_pkg::result_t res_s2
);
	import tfs_pkg::*;

	// Free when empty or draining this cycle
	assign out_free = !res_valid_s2 || out_ready;

	// Hold, load or drop the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (load) begin
			res_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

FILE: rtl/telegram_frame_segmenter.sv
// The transaction that completes a frame passes the input register, the segmenting logic
// and the output register. Throughput: one input byte per cycle unless a finished frame
// finds the output register full; the two registers let a new byte enter while a finished
// frame waits for the sink. Reset (arst_n low) empties both registers and returns the
// segmenter to the start of a telegram at once.
// ----------------------------------------------------------------------------
// Telegram frame segmenter
// Splits telegram bytes into short, start and continuation CAN frames.
// ----------------------------------------------------------------------------
module telegram_frame_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  op_code,
	input  logic [5:0]  unit_id,
	input  logic [5:0]  function_id,
	input  logic [1:0]  group_id,
	input  logic [15:0] body_len,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte0,
	output logic [7:0]  byte1,
	output logic [7:0]  byte2,
	output logic [7:0]  byte3,
	output logic [7:0]  byte4,
	output logic [7:0]  byte5,
	output logic [7:0]  byte6,
	output logic [7:0]  byte7,
	output logic [3:0]  frame_len,
	output logic        status,
	output logic        last_frame,
	output logic [5:0]  frame_count
);
	import tfs_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    res_valid;
	logic    out_free;
	result_t res;
	result_t res_s2;

	// Gather the input fields
	assign in_item = '{op_code: op_code, unit_id: unit_id, function_id: function_id,
		group_id: group_id, body_len: body_len, data_byte: data_byte};

	tfs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tfs_seg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	tfs_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res_valid),
		.res          (res),
		.out_ready    (out_ready),
		.out_free     (out_free),
		.res_valid_s2 (out_valid),
		.res_s2       (res_s2)
	);

	// Drive the result fields
	assign byte0       = res_s2.frame[0];
	assign byte1       = res_s2.frame[1];
	assign byte2       = res_s2.frame[2];
	assign byte3       = res_s2.frame[3];
	assign byte4       = res_s2.frame[4];
	assign byte5       = res_s2.frame[5];
	assign byte6       = res_s2.frame[6];
	assign byte7       = res_s2.frame[7];
	assign frame_len   = res_s2.frame_len;
	assign status      = logic'(res_s2.status);
	assign last_frame  = res_s2.last_frame;
	assign frame_count = res_s2.frame_count;

endmodule

FILE: rtl/tfs_checker.sv
// ----------------------------------------------------------------------------
// Telegram frame segmenter port checker
// Watches result transactions on the top-level ports for frame consistency.
// ----------------------------------------------------------------------------
`include "telegram_frame_segmenter_macros.svh"

module tfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte0,
	input logic [7:0] byte7,
	input logic [3:0] frame_len,
	input logic       status,
	input logic       last_frame,
	input logic [5:0] frame_count
);
	import tfs_pkg::*;

	// A refusal carries no frame and closes the telegram
	`TFS_ASSERT_NOW(a_refusal_shape, clk, arst_n, out_valid && status,
		frame_len == 4'd0 && last_frame && frame_count == 6'd0 && byte0 == 8'd0)

	// A good frame holds between two and eight bytes
	`TFS_ASSERT_NOW(a_frame_len_range, clk, arst_n, out_valid && !status,
		frame_len >= FILL_SHORT_HDR && frame_len <= FILL_FULL && frame_count != 6'd0)

	// A first frame that is not the last one is a full start frame
	`TFS_ASSERT_NOW(a_start_frame, clk, arst_n,
		out_valid && !status && frame_count == 6'd1 && !last_frame,
		frame_len == FILL_FULL && byte0[7:6] == START_MARK[7:6])

	// Unused tail bytes read as zero
	`TFS_ASSERT_NOW(a_tail_zero, clk, arst_n, out_valid && frame_len < FILL_FULL,
		byte7 == 8'd0)

	// A stalled result stays offered
	`TFS_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(frame_len) && $stable(frame_count) && $stable(byte0))

endmodule

bind telegram_frame_segmenter tfs_checker u_tfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.byte0       (byte0),
	.byte7       (byte7),
	.frame_len   (frame_len),
	.status      (status),
	.last_frame  (last_frame),
	.frame_count (frame_count)
);

FILE: tb/telegram_frame_segmenter_tb.sv
// ----------------------------------------------------------------------------
// Telegram frame segmenter testbench
// Feeds whole telegrams (short, start/continuation, empty and refused) through
// the segmenter under random input bursts and output stalls, predicts every
// frame in a local model and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module telegram_frame_segmenter_tb;

	import tfs_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 450;
	localparam int TAIL_CYCLES   = 8;
	localparam int HOLDOFF_LEN   = 300;
	localparam int REPORT_LIMIT  = 50;

	logic        clk;
	logic        arst_n;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	item_t       offer     = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
	logic [3:0]  frame_len;
	logic        status;
	logic        last_frame;
	logic [5:0]  frame_count;

	telegram_frame_segmenter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op_code     (offer.op_code),
		.unit_id     (offer.unit_id),
		.function_id (offer.function_id),
		.group_id    (offer.group_id),
		.body_len    (offer.body_len),
		.data_byte   (offer.data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte0       (byte0),
		.byte1       (byte1),
		.byte2       (byte2),
		.byte3       (byte3),
		.byte4       (byte4),
		.byte5       (byte5),
		.byte6       (byte6),
		.byte7       (byte7),
		.frame_len   (frame_len),
		.status      (status),
		.last_frame  (last_frame),
		.frame_count (frame_count)
	);

	// Items waiting to be offered and frames waiting to come out
	item_t   byte_items[$];
	result_t frames_due[$];

	// Segmenter state mirror
	logic [7:0] taken;
	byte_t      frame_buf [FRAME_BYTES];
	logic [3:0] fill;
	logic [3:0] cont_idx;
	logic [5:0] sent_frames;
	logic [7:0] tele_len;
	logic [1:0] tele_group;

	int items_queued   = 0;
	int items_accepted = 0;
	int frames_seen    = 0;
	int mismatches     = 0;
	int telegrams      = 0;
	int refusals       = 0;
	int longest_body   = 0;
	int cycle_count    = 0;
	int gap_left       = 0;
	int burst_left     = 1;
	int hold_left      = 0;
	int holdoffs_done  = 0;
	int ready_mode     = 0;
	int mode_left      = 0;

	// Close the frame under construction and queue it as expected output
	function automatic void emit_frame(input logic [3:0] len, input status_t st,
			input logic last, input logic [5:0] count);
		result_t r;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			r.frame[i] = (i < len) ? frame_buf[i] : 8'h00;
			frame_buf[i] = 8'h00;
		end
		r.frame_len   = len;
		r.status      = st;
		r.last_frame  = last;
		r.frame_count = count;
		frames_due.push_back(r);
	endfunction

	// Advance the segmenter mirror by one accepted item
	function automatic void segment_item(input item_t it);
		byte_t h0;
		byte_t h1;
		logic  done;
		if (taken == 8'd0) begin
			h0 = {it.op_code, it.unit_id[5:2]};
			h1 = {it.unit_id[1:0], it.function_id};
			for (int i = 0; i < FRAME_BYTES; i++)
				frame_buf[i] = 8'h00;
			if (it.body_len > MAX_BODY_LEN) begin
				fill = 4'd0;
				emit_frame(4'd0, ST_REFUSED, 1'b1, 6'd0);
				return;
			end
			tele_len    = it.body_len[7:0];
			tele_group  = it.group_id;
			sent_frames = 6'd0;
			cont_idx    = 4'd0;
			if (it.body_len <= 16'(SHORT_MAX_LEN)) begin
				frame_buf[0] = h0;
				frame_buf[1] = h1;
				fill = FILL_SHORT_HDR;
				// Empty body: header-only frame, data ignored
				if (it.body_len == 16'd0) begin
					sent_frames = 6'd1;
					emit_frame(FILL_SHORT_HDR, ST_OK, 1'b1, 6'd1);
					fill = 4'd0;
					return;
				end
			end else begin
				frame_buf[0] = START_MARK | {2'b00, it.group_id, 4'h0};
				frame_buf[1] = it.body_len[7:0];
				frame_buf[2] = h0;
				frame_buf[3] = h1;
				fill = FILL_START_HDR;
			end
		end else if (tele_len > SHORT_MAX_LEN && taken >= START_BODY_BYTES
				&& fill == 4'd0) begin
			frame_buf[0] = CONT_MARK | {2'b00, tele_group, cont_idx};
			fill = FILL_CONT_HDR;
		end

		frame_buf[fill[2:0]] = it.data_byte;
		fill  = fill + 4'd1;
		taken = taken + 8'd1;
		done  = (taken == tele_len);

		if (tele_len <= SHORT_MAX_LEN) begin
			if (!done)
				return;
			sent_frames = 6'd1;
			emit_frame(fill, ST_OK, 1'b1, 6'd1);
			fill  = 4'd0;
			taken = 8'd0;
			return;
		end

		// Start frame closes after its four body bytes
		if (taken == START_BODY_BYTES) begin
			sent_frames = sent_frames + 6'd1;
			emit_frame(FILL_FULL, ST_OK, 1'b0, sent_frames);
			fill = 4'd0;
			return;
		end

		if (fill >= FILL_FULL || done) begin
			sent_frames = sent_frames + 6'd1;
			emit_frame(fill, ST_OK, done, sent_frames);
			cont_idx = cont_idx + 4'd1;
			fill = 4'd0;
			if (done)
				taken = 8'd0;
		end
	endfunction

	// Build one telegram; items after the first carry random noise in every field
	function automatic void queue_telegram(input logic [15:0] blen, input logic [3:0] op,
			input logic [5:0] unit, input logic [5:0] fn, input logic [1:0] grp);
		item_t       it;
		logic [63:0] noise;
		int          count;
		count = (blen > MAX_BODY_LEN || blen == 16'd0) ? 1 : int'(blen);
		for (int k = 0; k < count; k++) begin
			noise = {$urandom, $urandom};
			it = noise[41:0];
			if (k == 0) begin
				it.op_code     = op;
				it.unit_id     = unit;
				it.function_id = fn;
				it.group_id    = grp;
				it.body_len    = blen;
			end
			byte_items.push_back(it);
		end
		items_queued += count;
		telegrams++;
		if (blen > MAX_BODY_LEN)
			refusals++;
		else if (int'(blen) > longest_body)
			longest_body = int'(blen);
	endfunction

	function automatic void queue_random_telegram(input logic [15:0] blen);
		queue_telegram(blen, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
	endfunction

	function automatic void report_field(input string name, input logic [7:0] want,
			input logic [7:0] seen);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name,
				want, seen);
		else if (mismatches == REPORT_LIMIT + 1)
			$display("%0t: further mismatch reports suppressed", $time);
	endfunction

	function automatic void check_frame(input result_t want, input result_t seen);
		for (int i = 0; i < FRAME_BYTES; i++)
			if (seen.frame[i] !== want.frame[i])
				report_field($sformatf("byte%0d", i), want.frame[i], seen.frame[i]);
		if (seen.frame_len !== want.frame_len)
			report_field("frame_len", 8'(want.frame_len), 8'(seen.frame_len));
		if (seen.status !== want.status)
			report_field("status", 8'(want.status), 8'(seen.status));
		if (seen.last_frame !== want.last_frame)
			report_field("last_frame", 8'(want.last_frame), 8'(seen.last_frame));
		if (seen.frame_count !== want.frame_count)
			report_field("frame_count", 8'(want.frame_count), 8'(seen.frame_count));
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Drive input transactions in bursts separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			offer      <= '0;
			gap_left   = 0;
			burst_left = 1;
			taken       = 8'd0;
			fill        = 4'd0;
			cont_idx    = 4'd0;
			sent_frames = 6'd0;
			tele_len    = 8'd0;
			tele_group  = 2'd0;
			for (int i = 0; i < FRAME_BYTES; i++)
				frame_buf[i] = 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				segment_item(offer);
				items_accepted <= items_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || byte_items.size() == 0) begin
					if (gap_left > 0)
						gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else begin
					offer    <= byte_items.pop_front();
					in_valid <= 1'b1;
					burst_left = burst_left - 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// Accept output transactions: random stall modes plus two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (holdoffs_done < 2 && frames_seen >= 20 + 100 * holdoffs_done) begin
			holdoffs_done = holdoffs_done + 1;
			hold_left = HOLDOFF_LEN;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(8, 40);
			end
			mode_left = mode_left - 1;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Check each output transaction against the oldest expected frame
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen.frame       = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
			seen.frame_len   = frame_len;
			seen.status      = status_t'(status);
			seen.last_frame  = last_frame;
			seen.frame_count = frame_count;
			if (frames_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected frame, expected none, actual byte0 0x%02h len %0d",
					$time, byte0, frame_len);
			end else begin
				want = frames_due.pop_front();
				check_frame(want, seen);
			end
			frames_seen <= frames_seen + 1;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int          pick;
		logic        long_done;
		arst_n = 1'b0;
		long_done = 1'b0;

		// Directed: header extremes, empty body, refusals, short and long bodies
		queue_telegram(16'd0, 4'hF, 6'h3F, 6'h3F, 2'd3);
		queue_telegram(16'd0, 4'h0, 6'h00, 6'h00, 2'd0);
		queue_telegram(16'd256, 4'hA, 6'h15, 6'h2A, 2'd1);
		queue_telegram(16'hFFFF, 4'h5, 6'h2A, 6'h15, 2'd2);
		queue_telegram(16'd1, 4'hF, 6'h00, 6'h3F, 2'd0);
		queue_telegram(16'd6, 4'h0, 6'h3F, 6'h00, 2'd3);
		queue_telegram(16'd7, 4'h9, 6'h21, 6'h12, 2'd3);
		queue_telegram(16'd11, 4'h6, 6'h0C, 6'h33, 2'd2);

		// Random telegrams, mostly bodies of 30 bytes or fewer, one full-length body to wrap the index
		while (items_queued < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (!long_done && items_queued >= 150) begin
				queue_random_telegram(16'd255);
				long_done = 1'b1;
			end else if (pick < 8)
				queue_random_telegram(16'($urandom_range(256, 65535)));
			else if (pick < 14)
				queue_random_telegram(16'd0);
			else if (pick < 50)
				queue_random_telegram(16'($urandom_range(1, 6)));
			else if (pick < 88)
				queue_random_telegram(16'($urandom_range(7, 30)));
			else if (pick < 97)
				queue_random_telegram(16'($urandom_range(31, 80)));
			else
				queue_random_telegram(16'($urandom_range(117, 160)));
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for every item to be taken and every frame to arrive
		while ((items_accepted < items_queued || frames_due.size() != 0)
				&& cycle_count < CYCLE_LIMIT)
			@(negedge clk);

		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d items accepted, %0d frames outstanding",
				$time, items_accepted, items_queued, frames_due.size());
			$display("Mismatches found");
			$finish;
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			$display("Ran %0d telegrams (%0d refused, longest body %0d bytes) as %0d items",
				telegrams, refusals, longest_body, items_queued);
			$display("Compared %0d frames under bursty input and stalled output",
				frames_seen);
			if (mismatches == 0 && frames_due.size() == 0)
				$display("No mismatches found");
			else
				$display("Mismatches found");
			$finish;
		end
	end

endmodule
